@@ hdl/rhp_pkg.sv @@
// Shared types, constants and the divider step function for the RGB to HSV converter.
package rhp_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned HUE_W         = 15;
  localparam int unsigned SAT_W         = 13;
  localparam int unsigned HUE_Q_W       = 12;
  localparam int unsigned DIV_W         = 20;
  localparam int unsigned DIV_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES    = DIV_W / DIV_PER_STAGE;
  // Front end, divider setup, divider stages and the output register.
  localparam int unsigned PIPE_DEPTH    = DIV_STAGES + 3;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [SAT_W-1:0]  sat_t;

  localparam hue_t HUE_FULL   = 15'd23040;
  localparam hue_t HUE_ZERO   = 15'd0;
  localparam hue_t HUE_GREEN  = 15'd7680;
  localparam hue_t HUE_BLUE   = 15'd15360;
  localparam sat_t SAT_ZERO   = 13'd0;

  // Remainder stays below the divisor; the dividend shifts out of the top of
  // xq while quotient bits shift in at the bottom.
  typedef struct packed {
    chan_t            rem;
    logic [DIV_W-1:0] xq;
  } div_t;

  typedef struct packed {
    chan_t value;
    chan_t range;
    chan_t diff;
    logic  neg;
    logic  grey;
    logic  black;
    hue_t  offset;
    div_t  hdiv;
    div_t  sdiv;
  } pipe_t;

  // One restoring division step.
  function automatic div_t div_step(div_t s, chan_t d);
    logic [CHAN_W:0] t;
    div_t            r;
    t = {s.rem, s.xq[DIV_W-1]};
    if (t >= {1'b0, d}) begin
      r.rem = CHAN_W'(t - {1'b0, d});
      r.xq  = {s.xq[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = t[CHAN_W-1:0];
      r.xq  = {s.xq[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ hdl/rhp_if.sv @@
// Valid/ready channel interfaces for RGB pixels and HSV results.
interface rhp_rgb_if;
  import rhp_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhp_hsv_if;
  import rhp_pkg::*;
  logic  valid;
  logic  ready;
  hue_t  hue;
  sat_t  saturation;
  chan_t value;
  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

@@ hdl/rgb_to_hsv_pixel.sv @@
// Top level: pipelined RGB to HSV pixel converter.
//
// A pixel transfers on the pixel channel when pixel.valid and pixel.ready are
// both high; its hue, saturation and value transfer on the hsv channel the
// same way. Hue is in 1/64 degree (0 to 23039), saturation is unsigned Q12
// (4096 is 1.0) and value is the largest channel byte.
//
// The block is an eight-stage pipeline: a front stage finds max, min, the
// hue sector and the signed difference; a setup stage forms both dividends;
// five stages each retire four bits of two restoring dividers (hue and
// saturation); the last stage adds the sector offset, wraps the hue and
// holds the result. Throughput is one pixel per cycle while the receiver is
// ready; each result passes through every stage register before it is offered.
//
// Every stage carries its own valid bit and loads when it is empty or when
// the stage after it moves, so a stall on hsv.ready fills the empty stages
// before pixel.ready drops and nothing is lost or repeated. Synchronous reset
// clears all valid bits; the data registers are not reset.
module rgb_to_hsv_pixel (
  input logic      clk,
  input logic      rst,
  rhp_rgb_if.sink  pixel,
  rhp_hsv_if.source hsv
);
  import rhp_pkg::*;

  localparam int unsigned NS = PIPE_DEPTH;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  pipe_t         stg [NS-1];
  pipe_t         stg_next [NS-1];

  hue_t  hue_reg;
  sat_t  sat_reg;
  chan_t value_reg;
  hue_t  hue_next;
  sat_t  sat_next;

  // Front stage signals.
  logic  red_max;
  logic  green_max;
  chan_t mx;
  chan_t mn;
  chan_t op_a;
  chan_t op_b;
  hue_t  off;
  logic [HUE_Q_W-1:0] n15;
  hue_t  hue_q;
  hue_t  hue_sum;

  // A stage may load when it is empty or when its content moves on.
  always_comb begin
    en[NS-1] = !vld[NS-1] || hsv.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pixel.ready = en[0];

  // Front stage: red wins ties for the maximum, then green.
  always_comb begin
    red_max   = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
    green_max = !red_max && (pixel.green >= pixel.blue);
    if (red_max) begin
      mx   = pixel.red;
      op_a = pixel.green;
      op_b = pixel.blue;
      off  = (pixel.green >= pixel.blue) ? HUE_ZERO : HUE_FULL;
    end else if (green_max) begin
      mx   = pixel.green;
      op_a = pixel.blue;
      op_b = pixel.red;
      off  = HUE_GREEN;
    end else begin
      mx   = pixel.blue;
      op_a = pixel.red;
      op_b = pixel.green;
      off  = HUE_BLUE;
    end
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;

    stg_next[0]        = '0;
    stg_next[0].value  = mx;
    stg_next[0].range  = mx - mn;
    stg_next[0].neg    = op_a < op_b;
    stg_next[0].diff   = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
    stg_next[0].grey   = (mx == mn);
    stg_next[0].black  = (mx == '0);
    stg_next[0].offset = off;
  end

  // Setup stage: hue dividend is 3840 * diff = (15 * diff) << 8, saturation
  // dividend is range << 12.
  always_comb begin
    n15               = {stg[0].diff, 4'b0} - {4'b0, stg[0].diff};
    stg_next[1]       = stg[0];
    stg_next[1].hdiv  = '{rem: '0, xq: {n15, 8'b0}};
    stg_next[1].sdiv  = '{rem: '0, xq: {stg[0].range, 12'b0}};
  end

  // Divider stages, four quotient bits each.
  for (genvar k = 2; k < NS - 1; k++) begin : g_div
    always_comb begin
      stg_next[k] = stg[k-1];
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        stg_next[k].hdiv = div_step(stg_next[k].hdiv, stg[k-1].range);
        stg_next[k].sdiv = div_step(stg_next[k].sdiv, stg[k-1].value);
      end
    end
  end

  // Output stage: apply the sector offset and wrap into one turn.
  always_comb begin
    hue_q = HUE_W'(stg[NS-2].hdiv.xq[HUE_Q_W-1:0]);
    if (stg[NS-2].neg) begin
      hue_sum = stg[NS-2].offset - hue_q;
    end else begin
      hue_sum = stg[NS-2].offset + hue_q;
    end
    if (hue_sum >= HUE_FULL) begin
      hue_sum = hue_sum - HUE_FULL;
    end
    hue_next = stg[NS-2].grey ? HUE_ZERO : hue_sum;
    sat_next = stg[NS-2].black ? SAT_ZERO : stg[NS-2].sdiv.xq[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pixel.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
    for (int i = 0; i < NS - 1; i++) begin
      if (en[i]) begin
        stg[i] <= stg_next[i];
      end
    end
    if (en[NS-1]) begin
      hue_reg   <= hue_next;
      sat_reg   <= sat_next;
      value_reg <= stg[NS-2].value;
    end
  end

  assign hsv.valid      = vld[NS-1];
  assign hsv.hue        = hue_reg;
  assign hsv.saturation = sat_reg;
  assign hsv.value      = value_reg;

endmodule

@@ hdl/rhp_checker.sv @@
// Port-level assertions for the RGB to HSV converter and their bind.
module rhp_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input rhp_pkg::hue_t   hue,
  input rhp_pkg::sat_t   saturation,
  input rhp_pkg::chan_t  value
);
  import rhp_pkg::*;

  // A result offered but not taken stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
      && $stable(value))
    else $error("hsv result changed or vanished under stall");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("hsv valid after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < HUE_FULL) && (saturation <= 13'd4096))
    else $error("hue or saturation out of range");

  // A black pixel has no saturation and no hue.
  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && (value == '0) |-> (saturation == SAT_ZERO) && (hue == HUE_ZERO))
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation only comes from a grey pixel, whose hue is zero.
  a_grey: assert property (@(posedge clk) disable iff (rst)
    out_valid && (saturation == SAT_ZERO) |-> (hue == HUE_ZERO))
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_pixel rhp_checker u_rhp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (hsv.valid),
  .out_ready  (hsv.ready),
  .hue        (hsv.hue),
  .saturation (hsv.saturation),
  .value      (hsv.value)
);

@@ tb/rgb_to_hsv_pixel_tb.sv @@
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_tb;
  import rhp_pkg::*;

  // Hue is measured in 1/64 degree, so a full turn is 360 * 64 and one
  // 60-degree sector is 3840. Saturation is unsigned Q12.
  localparam int unsigned HUE_TURN   = 23040;
  localparam int unsigned HUE_SIXTH  = 3840;
  localparam int unsigned SAT_UNITY  = 4096;
  localparam int unsigned DRAIN_LIMIT = 5000;

  // One expected HSV result, at the widths of the result channel.
  typedef struct {
    hue_t  hue;
    sat_t  saturation;
    chan_t value;
  } hsv_pixel_t;

  logic clk;
  logic rst;

  rhp_rgb_if pixel_ch ();
  rhp_hsv_if hsv_ch ();

  rgb_to_hsv_pixel i_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .hsv   (hsv_ch)
  );

  // Expected results, oldest first. A pixel's result is appended at the edge
  // where its transfer on the pixel channel happens.
  hsv_pixel_t hsv_pending[$];

  int  pixels_sent;
  int  results_seen;
  int  mismatches;
  // While this is set, both the sender and the receiver insert random
  // idle bursts; the final test clears it to run at full rate.
  bit  idle_enable;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every mismatch goes through here so that the count stays in one place.
  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Hue within one sector: the sector base plus or minus the truncated
  // quotient 3840 * |a - b| / span. The sign follows a - b, so truncation is
  // toward zero in both directions.
  function automatic int unsigned sector_hue(input int unsigned base, input chan_t a,
                                             input chan_t b, input chan_t span);
    int unsigned mag;
    if (a >= b) begin
      mag = (HUE_SIXTH * (a - b)) / span;
      return base + mag;
    end
    mag = (HUE_SIXTH * (b - a)) / span;
    return base - mag;
  endfunction

  // Predicts the converter's result for one pixel. Red wins ties for the
  // maximum, then green; a grey pixel has hue zero, and a black pixel also
  // has zero saturation.
  function automatic hsv_pixel_t hsv_of_pixel(input chan_t r, input chan_t g, input chan_t b);
    chan_t       hi;
    chan_t       lo;
    chan_t       span;
    int unsigned h;
    hsv_pixel_t  res;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = hi - lo;
    if (span == 0) begin
      h = 0;
    end else if (hi == r) begin
      // Below the red axis the hue wraps around from a full turn.
      h = sector_hue((g >= b) ? 0 : HUE_TURN, g, b, span);
    end else if (hi == g) begin
      h = sector_hue(2 * HUE_SIXTH, b, r, span);
    end else begin
      h = sector_hue(4 * HUE_SIXTH, r, g, span);
    end
    h = h % HUE_TURN;
    res.hue        = hue_t'(h);
    res.saturation = (hi == 0) ? sat_t'(0) : sat_t'((SAT_UNITY * span) / hi);
    res.value      = hi;
    return res;
  endfunction

  function automatic chan_t any_chan();
    return chan_t'($urandom_range(0, 255));
  endfunction

  // Offers one pixel and returns at the edge of its transfer. Valid is left
  // high so that back-to-back pixels need no gap; an idle burst lowers it
  // only when idling is enabled.
  task automatic push_pixel(input chan_t r, input chan_t g, input chan_t b);
    int gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red   <= r;
    pixel_ch.green <= g;
    pixel_ch.blue  <= b;
    do @(posedge clk); while (!pixel_ch.ready);
    hsv_pending.push_back(hsv_of_pixel(r, g, b));
    pixels_sent++;
  endtask

  // Corners of the color cube, each sector, every kind of tie for the
  // maximum, the wrap just below 360 degrees, the smallest nonzero ranges,
  // and black and grey pixels.
  task automatic test_directed();
    push_pixel(8'd0,   8'd0,   8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd255, 8'd0,   8'd0);
    push_pixel(8'd0,   8'd255, 8'd0);
    push_pixel(8'd0,   8'd0,   8'd255);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd0,   8'd255, 8'd255);
    push_pixel(8'd255, 8'd0,   8'd255);
    push_pixel(8'd255, 8'd0,   8'd1);
    push_pixel(8'd255, 8'd1,   8'd0);
    push_pixel(8'd200, 8'd200, 8'd100);
    push_pixel(8'd100, 8'd200, 8'd200);
    push_pixel(8'd200, 8'd100, 8'd200);
    push_pixel(8'd1,   8'd0,   8'd0);
    push_pixel(8'd0,   8'd1,   8'd0);
    push_pixel(8'd0,   8'd0,   8'd1);
    push_pixel(8'd255, 8'd254, 8'd255);
    push_pixel(8'd1,   8'd1,   8'd0);
    push_pixel(8'd255, 8'd128, 8'd0);
    push_pixel(8'd0,   8'd128, 8'd255);
    push_pixel(8'd254, 8'd255, 8'd0);
    push_pixel(8'd170, 8'd85,  8'd255);
  endtask

  // Mostly uniform pixels. Every few hundred pixels idling is switched off
  // for a stretch so that runs of back-to-back transfers occur as well.
  task automatic test_random_pixels(input int count);
    chan_t base;
    for (int i = 0; i < count; i++) begin
      idle_enable = ((i / 150) % 3) != 2;
      if ($urandom_range(0, 9) < 8) begin
        push_pixel(any_chan(), any_chan(), any_chan());
      end else begin
        // Nearly grey pixels give ranges of zero to two, where the hue
        // quotient is at its largest per unit of difference.
        base = chan_t'($urandom_range(2, 253));
        push_pixel(base + chan_t'($urandom_range(0, 2)) - 8'd1,
                   base + chan_t'($urandom_range(0, 2)) - 8'd1,
                   base + chan_t'($urandom_range(0, 2)) - 8'd1);
      end
    end
    idle_enable = 1'b1;
  endtask

  // Pixels with two or three equal channels, so that the tie order for the
  // maximum and the grey case are hit many times with random values.
  task automatic test_tied_channels(input int count);
    chan_t a;
    chan_t b;
    for (int i = 0; i < count; i++) begin
      a = any_chan();
      b = any_chan();
      case ($urandom_range(0, 3))
        0: begin
          push_pixel(a, a, b);
        end
        1: begin
          push_pixel(b, a, a);
        end
        2: begin
          push_pixel(a, b, a);
        end
        default: begin
          push_pixel(a, a, a);
        end
      endcase
    end
  endtask

  // Full-rate stream at the end of the run: no idling on either side.
  task automatic test_streaming(input int count);
    idle_enable = 1'b0;
    for (int i = 0; i < count; i++) begin
      push_pixel(any_chan(), any_chan(), any_chan());
    end
  endtask

  // Result side: checks each transfer against the oldest expectation and
  // then decides the ready for the next cycle, with random stall bursts.
  initial begin : hsv_sink
    hsv_pixel_t want;
    int         stall_left;
    stall_left = 0;
    hsv_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hsv_ch.valid && hsv_ch.ready) begin
        results_seen++;
        if (hsv_pending.size() == 0) begin
          report_mismatch($sformatf("result with no pixel pending: hue %0d sat %0d value %0d",
                                    hsv_ch.hue, hsv_ch.saturation, hsv_ch.value));
        end else begin
          want = hsv_pending.pop_front();
          if (hsv_ch.hue !== want.hue) begin
            report_mismatch($sformatf("result %0d hue %0d, expected %0d",
                                      results_seen, hsv_ch.hue, want.hue));
          end
          if (hsv_ch.saturation !== want.saturation) begin
            report_mismatch($sformatf("result %0d saturation %0d, expected %0d",
                                      results_seen, hsv_ch.saturation, want.saturation));
          end
          if (hsv_ch.value !== want.value) begin
            report_mismatch($sformatf("result %0d value %0d, expected %0d",
                                      results_seen, hsv_ch.value, want.value));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        hsv_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        // This cycle is the first of a random burst of stalled cycles.
        stall_left = $urandom_range(0, 10);
        hsv_ch.ready <= 1'b0;
      end else begin
        hsv_ch.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, the tests in turn, then drain and verdict.
  initial begin : main_seq
    int cycles;
    pixels_sent  = 0;
    results_seen = 0;
    mismatches   = 0;
    idle_enable  = 1'b1;
    rst            <= 1'b1;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red   <= '0;
    pixel_ch.green <= '0;
    pixel_ch.blue  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_pixels(1400);
    test_tied_channels(300);
    test_streaming(300);
    pixel_ch.valid <= 1'b0;

    // Wait for the pipeline to empty, then wait longer still so that any
    // stray result after the last expected one is still caught.
    cycles = 0;
    while (hsv_pending.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (hsv_pending.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", hsv_pending.size()));
    end

    $display("Converted %0d pixels and checked %0d results, %0d mismatches.",
             pixels_sent, results_seen, mismatches);
    $display("Covered cube corners, every sector and tie, grey and black, and full-rate streams.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with every idle burst.
  initial begin : watchdog
    #5000000;
    $display("Timeout after %0t with %0d results pending.", $time, hsv_pending.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
